FILE: sv/qpe_pkg.sv
package qpe_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_EQ = 8'h3D;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] LEAD_2_MAX = 8'hDF;
  localparam logic [7:0] LEAD_3_MAX = 8'hEF;
  localparam logic [7:0] LEAD_4_MAX = 8'hF4;
  localparam logic [7:0] MAX_LINE_RESET = 8'd75;

  localparam logic [1:0] REG_MAX_LINE = 2'd0;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_ESC  = 2'd1,
    CMD_CRLF = 2'd2
  } cmd_kind_t;

  // one request from front to back: a body, optionally preceded by a soft break
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        brk;
    logic        last;
  } qpe_cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

FILE: sv/quoted_printable_encoder.sv
// Quoted-printable encoder. Raw bytes enter on in_byte/in_last, encoded text
// leaves on out_byte/out_last, one byte per cycle unless stalled. Each byte is
// held until the next one arrives (look-ahead for CR LF and space-before-CR);
// in_last flushes it and resets the line position. The front end takes one
// request per cycle while the queue has room; a final request that flushes a
// held byte stalls input until its own byte is queued too. A copied byte
// gives 1 output byte, an escape 3, CR LF 2, a soft break 3 more. max_line
// sits at APB address 0 and should be written only while the block is idle.
module quoted_printable_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qpe_pkg::*;

  logic [7:0] max_line;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  qpe_cmd_t   q_in;
  qpe_cmd_t   q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_LINE) ? {24'd0, max_line} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line <= MAX_LINE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_LINE) begin
      max_line <= pwdata[7:0];
    end
  end

  qpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .max_line (max_line),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_in)
  );

  qpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  qpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: sv/qpe_queue.sv
module qpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qpe_pkg::qpe_cmd_t push_cmd,
  input  logic             pop,
  output qpe_pkg::qpe_cmd_t head,
  output logic             full,
  output logic             empty
);
  import qpe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qpe_cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  wire do_push = push && !full;
  wire do_pop  = pop && !empty;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/qpe_front.sv
module qpe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [7:0]        max_line,
  input  logic              q_full,
  output logic              push,
  output qpe_pkg::qpe_cmd_t push_cmd
);
  import qpe_pkg::*;

  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] pend_byte;
  logic       pend_valid;
  logic [7:0] line_pos;

  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic [7:0] pend_byte_next;
  logic       pend_valid_next;
  logic [7:0] line_pos_next;

  logic       accept;
  logic [7:0] enc_c;
  logic       has_next;
  logic       pair;
  logic       esc;
  logic [8:0] sum3;
  logic [8:0] sum1;
  logic [8:0] p3;
  logic [8:0] p1;
  logic [8:0] lim;
  logic       brk;
  logic [7:0] enc_pos;
  qpe_cmd_t   enc_cmd;

  assign in_stall = pend_valid || q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    enc_c    = pend_valid ? pend_byte : (held_valid ? held_byte : in_byte);
    has_next = !pend_valid && held_valid;
    pair     = !pend_valid && held_valid && held_byte == CHAR_CR && in_byte == CHAR_LF;
    esc = enc_c < CHAR_SP || enc_c >= CHAR_DEL || enc_c == CHAR_EQ ||
          (enc_c == CHAR_SP && has_next && in_byte == CHAR_CR);

    sum3 = {1'b0, line_pos} + 9'd3;
    sum1 = {1'b0, line_pos} + 9'd1;
    p3   = sum3[8] ? 9'd255 : sum3;
    p1   = sum1[8] ? 9'd255 : sum1;
    lim  = {1'b0, max_line};

    // escapes of UTF-8 lead bytes reserve room for the continuation escapes; escapes above LEAD_4_MAX never break
    if (esc) begin
      if (enc_c <= CHAR_DEL) begin
        brk = p3 > lim;
      end else if (enc_c <= LEAD_2_MAX) begin
        brk = p3 + 9'd3 > lim;
      end else if (enc_c <= LEAD_3_MAX) begin
        brk = p3 + 9'd6 > lim;
      end else if (enc_c <= LEAD_4_MAX) begin
        brk = p3 + 9'd9 > lim;
      end else begin
        brk = 1'b0;
      end
      enc_pos = brk ? 8'd3 : p3[7:0];
    end else begin
      brk     = p1 > lim;
      enc_pos = brk ? 8'd1 : p1[7:0];
    end

    enc_cmd.kind = esc ? CMD_ESC : CMD_LIT;
    enc_cmd.data = enc_c;
    enc_cmd.brk  = brk;
    enc_cmd.last = 1'b0;
  end

  always_comb begin
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    pend_byte_next  = pend_byte;
    pend_valid_next = pend_valid;
    line_pos_next   = line_pos;
    push            = 1'b0;
    push_cmd        = enc_cmd;

    if (pend_valid) begin
      if (!q_full) begin
        push            = 1'b1;
        push_cmd.last   = 1'b1;
        pend_valid_next = 1'b0;
        line_pos_next   = '0;
      end
    end else if (accept) begin
      if (held_valid) begin
        push = 1'b1;
        if (pair) begin
          push_cmd.kind   = CMD_CRLF;
          push_cmd.data   = CHAR_CR;
          push_cmd.brk    = 1'b0;
          push_cmd.last   = in_last;
          held_valid_next = 1'b0;
          line_pos_next   = '0;
        end else begin
          line_pos_next = enc_pos;
          if (in_last) begin
            held_valid_next = 1'b0;
            pend_valid_next = 1'b1;
            pend_byte_next  = in_byte;
          end else begin
            held_byte_next = in_byte;
          end
        end
      end else if (in_last) begin
        push          = 1'b1;
        push_cmd.last = 1'b1;
        line_pos_next = '0;
      end else begin
        held_byte_next  = in_byte;
        held_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= '0;
      held_valid <= 1'b0;
      pend_byte  <= '0;
      pend_valid <= 1'b0;
      line_pos   <= '0;
    end else begin
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      pend_byte  <= pend_byte_next;
      pend_valid <= pend_valid_next;
      line_pos   <= line_pos_next;
    end
  end

endmodule

FILE: sv/qpe_back.sv
module qpe_back (
  input  logic              clk,
  input  logic              rst,
  input  qpe_pkg::qpe_cmd_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import qpe_pkg::*;

  logic [2:0] idx;
  logic [2:0] body_len;
  logic [2:0] total_len;
  logic [2:0] boff;
  logic       final_byte;
  logic       advance;
  logic [7:0] sel_byte;

  always_comb begin
    case (head.kind)
      CMD_LIT:  body_len = 3'd1;
      CMD_ESC:  body_len = 3'd3;
      CMD_CRLF: body_len = 3'd2;
      default:  body_len = 3'd1;
    endcase
    total_len  = head.brk ? body_len + 3'd3 : body_len;
    final_byte = (idx == total_len - 3'd1);
    boff       = head.brk ? idx - 3'd3 : idx;

    if (head.brk && idx < 3'd3) begin
      // soft line break "=" CR LF
      case (idx)
        3'd0:    sel_byte = CHAR_EQ;
        3'd1:    sel_byte = CHAR_CR;
        default: sel_byte = CHAR_LF;
      endcase
    end else begin
      case (head.kind)
        CMD_ESC: begin
          case (boff)
            3'd0:    sel_byte = CHAR_EQ;
            3'd1:    sel_byte = hex_digit(head.data[7:4]);
            default: sel_byte = hex_digit(head.data[3:0]);
          endcase
        end
        CMD_CRLF: sel_byte = (boff == 3'd0) ? CHAR_CR : CHAR_LF;
        default:  sel_byte = head.data;
      endcase
    end
  end

  assign advance = !q_empty && (!out_valid || !out_stall);
  assign pop     = advance && final_byte;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= sel_byte;
      out_last <= final_byte && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/qpe_checker.sv
module qpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last
);
  import qpe_pkg::*;

  // last accepted output byte was CR
  logic prev_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cr <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_cr <= (out_byte == CHAR_CR);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output request changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_text: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_byte >= CHAR_SP && out_byte < CHAR_DEL) ||
                  out_byte == CHAR_CR || out_byte == CHAR_LF)
    else $error("encoded byte is not printable text");

  a_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte == CHAR_LF |-> prev_cr)
    else $error("LF not preceded by CR");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import qpe_pkg::*;

  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] b;
    logic       l;
  } qp_char_t;

  // directed row: input byte, last mark, whether the expected text is typed in,
  // and that text (first byte in e[0])
  typedef struct packed {
    logic [7:0]       b;
    logic             l;
    logic             chk;
    logic [2:0]       n;
    logic [0:3][7:0]  e;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{"A",     1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{CHAR_EQ, 1'b0, 1'b1, 3'd1, '{"A", 0, 0, 0}},
    '{8'h00,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "3", "D", 0}},
    '{8'hFF,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "0", "0", 0}},
    '{CHAR_SP, 1'b0, 1'b1, 3'd3, '{CHAR_EQ, "F", "F", 0}},
    '{CHAR_CR, 1'b0, 1'b1, 3'd3, '{CHAR_EQ, "2", "0", 0}},
    '{CHAR_LF, 1'b0, 1'b1, 3'd2, '{CHAR_CR, CHAR_LF, 0, 0}},
    '{CHAR_CR, 1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{"x",     1'b0, 1'b1, 3'd3, '{CHAR_EQ, "0", "D", 0}},
    '{CHAR_DEL, 1'b0, 1'b1, 3'd1, '{"x", 0, 0, 0}},
    '{8'h80,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "7", "F", 0}},
    '{8'hE0,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "8", "0", 0}},
    '{8'hF4,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "E", "0", 0}},
    '{8'hF5,   1'b0, 1'b1, 3'd3, '{CHAR_EQ, "F", "4", 0}},
    '{CHAR_SP, 1'b1, 1'b1, 3'd4, '{CHAR_EQ, "F", "5", CHAR_SP}},
    '{CHAR_CR, 1'b1, 1'b1, 3'd3, '{CHAR_EQ, "0", "D", 0}},
    '{8'h7E,   1'b0, 1'b1, 3'd0, '{0, 0, 0, 0}},
    '{CHAR_CR, 1'b1, 1'b1, 3'd4, '{"~", CHAR_EQ, "0", "D"}},
    '{8'hEF,   1'b0, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{8'hF0,   1'b0, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{8'h1F,   1'b1, 1'b0, 3'd0, '{0, 0, 0, 0}},
    '{CHAR_LF, 1'b1, 1'b0, 3'd0, '{0, 0, 0, 0}}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quoted_printable_encoder u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // encoder mirror state
  logic [7:0] enc_held;
  logic       enc_held_v;
  logic [7:0] enc_pos;
  logic [7:0] enc_max;

  qp_char_t   step_text[$];
  qp_char_t   text_q[$];
  logic [7:0] msg_q[$];

  int  errors = 0;
  int  n_requests = 0;
  int  n_text = 0;
  int  n_settings = 0;
  int  stall_left = 0;
  bit  in_burst = 0;
  bit  out_burst = 0;

  task automatic report(input string what);
    errors++;
    if (errors <= 30) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("A") + 8'(nib) - 8'd10;
  endfunction

  task automatic emit(input logic [7:0] c);
    step_text.push_back('{c, 1'b0});
  endtask

  task automatic bump_pos(input int amt);
    int p;
    p = int'(enc_pos) + amt;
    enc_pos = (p > 255) ? 8'd255 : 8'(p);
  endtask

  task automatic encode_char(input logic [7:0] c, input bit has_next, input logic [7:0] nxt);
    bit esc;
    bit brk;
    int p;
    int lim;
    lim = int'(enc_max);
    esc = (c < 8'h20) || (c >= CHAR_DEL) || (c == CHAR_EQ) ||
          (c == CHAR_SP && has_next && nxt == CHAR_CR);
    if (esc) begin
      bump_pos(3);
      p = int'(enc_pos);
      // UTF-8 lead bytes reserve room for the rest of the sequence
      if (c <= CHAR_DEL) brk = p > lim;
      else if (c <= LEAD_2_MAX) brk = p + 3 > lim;
      else if (c <= LEAD_3_MAX) brk = p + 6 > lim;
      else if (c <= LEAD_4_MAX) brk = p + 9 > lim;
      else brk = 0;
      if (brk) begin
        emit(CHAR_EQ); emit(CHAR_CR); emit(CHAR_LF);
        enc_pos = 8'd3;
      end
      emit(CHAR_EQ);
      emit(hex_char(c[7:4]));
      emit(hex_char(c[3:0]));
    end else begin
      bump_pos(1);
      if (int'(enc_pos) > lim) begin
        emit(CHAR_EQ); emit(CHAR_CR); emit(CHAR_LF);
        enc_pos = 8'd1;
      end
      emit(c);
    end
  endtask

  // computes the encoded text caused by one request into step_text
  task automatic encode_request(input logic [7:0] b, input logic l);
    bit used;
    used = 0;
    step_text.delete();
    if (enc_held_v) begin
      if (enc_held == CHAR_CR && b == CHAR_LF) begin
        emit(CHAR_CR); emit(CHAR_LF);
        enc_pos = 0;
        used = 1;
      end else begin
        encode_char(enc_held, 1, b);
      end
      enc_held_v = 0;
      enc_held = 0;
    end
    if (!used) begin
      if (l) encode_char(b, 0, 8'h00);
      else begin
        enc_held = b;
        enc_held_v = 1;
      end
    end
    if (l) begin
      if (step_text.size() > 0) step_text[step_text.size() - 1].l = 1'b1;
      enc_pos = 0;
    end
  endtask

  task automatic send_request(input logic [7:0] b, input logic l);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    in_byte = b;
    in_last = l;
    do @(posedge clk); while (in_stall);
    n_requests++;
  endtask

  task automatic send_checked(input logic [7:0] b, input logic l);
    send_request(b, l);
    encode_request(b, l);
    foreach (step_text[i]) text_q.push_back(step_text[i]);
  endtask

  task automatic drain;
    while (text_q.size() != 0) @(posedge clk);
    // a held byte may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_line(input logic [7:0] v);
    @(negedge clk);
    in_valid = 0;
    drain();
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = 2'(4 * REG_MAX_LINE);
    pwdata = {8'($urandom), 16'($urandom), v};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    enc_max = v;
    n_settings++;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    @(negedge clk);
    psel = 1;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v)
      report($sformatf("max_line read back %h, expected %h", prdata[7:0], v));
    @(negedge clk);
    psel = 0; penable = 0;
  endtask

  task automatic add_piece;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) msg_q.push_back(8'($urandom_range(33, 126)));
    else if (r < 45) msg_q.push_back(CHAR_SP);
    else if (r < 52) begin
      msg_q.push_back(CHAR_SP); msg_q.push_back(CHAR_CR); msg_q.push_back(CHAR_LF);
    end else if (r < 60) begin
      msg_q.push_back(CHAR_CR); msg_q.push_back(CHAR_LF);
    end else if (r < 64) msg_q.push_back(CHAR_CR);
    else if (r < 67) msg_q.push_back(CHAR_LF);
    else if (r < 72) msg_q.push_back(8'($urandom_range(0, 31)));
    else if (r < 75) msg_q.push_back(CHAR_EQ);
    else if (r < 78) msg_q.push_back(CHAR_DEL);
    else if (r < 85) begin
      msg_q.push_back(8'($urandom_range(8'h80, LEAD_2_MAX)));
      msg_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (r < 90) begin
      msg_q.push_back(8'($urandom_range(8'hE0, LEAD_3_MAX)));
      repeat (2) msg_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (r < 94) begin
      msg_q.push_back(8'($urandom_range(8'hF0, LEAD_4_MAX)));
      repeat (3) msg_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (r < 97) msg_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
    else msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_message;
    foreach (msg_q[i]) send_checked(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic run_phase(input logic [7:0] lim, input int n_items, input int max_len);
    int sent;
    int len;
    set_max_line(lim);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      msg_q.delete();
      while (msg_q.size() < len) add_piece();
      while (msg_q.size() > len) void'(msg_q.pop_back());
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      send_message();
      sent += len;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1;
      stall_left--;
    end else begin
      out_stall = 0;
    end
  end

  always @(posedge clk) begin
    qp_char_t want;
    if (!rst && out_valid && !out_stall) begin
      n_text++;
      if (text_q.size() == 0) begin
        report($sformatf("unexpected output byte %h last %b", out_byte, out_last));
      end else begin
        want = text_q.pop_front();
        if (out_byte !== want.b)
          report($sformatf("output %0d: out_byte %h, expected %h", n_text, out_byte, want.b));
        if (out_last !== want.l)
          report($sformatf("output %0d: out_last %b, expected %b", n_text, out_last, want.l));
      end
      stall_left = out_burst ? 0 : $urandom_range(0, 5);
    end
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1;
    in_valid = 0; in_byte = 0; in_last = 0;
    out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    enc_held = 0; enc_held_v = 0; enc_pos = 0; enc_max = MAX_LINE_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed rows at the reset line length
    for (int i = 0; i < DIR_ROWS; i++) begin
      in_burst = (i >= 16);
      send_request(DIR_TBL[i].b, DIR_TBL[i].l);
      encode_request(DIR_TBL[i].b, DIR_TBL[i].l);
      if (DIR_TBL[i].chk) begin
        for (int k = 0; k < int'(DIR_TBL[i].n); k++)
          text_q.push_back('{DIR_TBL[i].e[k],
                             DIR_TBL[i].l && (k == int'(DIR_TBL[i].n) - 1)});
      end else begin
        foreach (step_text[k]) text_q.push_back(step_text[k]);
      end
    end

    run_phase(8'd10, 50, 24);
    run_phase(8'd250, 25, 40);
    run_phase(8'd0, 20, 8);

    // long run of escapes that never force a break: line position saturates
    set_max_line(8'd255);
    msg_q.delete();
    repeat (90) msg_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
    in_burst = 0;
    out_burst = 1;
    send_message();
    run_phase(8'd255, 10, 10);

    repeat (3) run_phase(8'($urandom_range(10, 250)), 20, 20);
    run_phase(8'd1, 20, 6);

    @(negedge clk);
    in_valid = 0;
    drain();

    $display("Encoded %0d requests into %0d output bytes over %0d line-length settings,",
             n_requests, n_text, n_settings);
    $display("including soft breaks, UTF-8 lead reservation and position saturation.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/qpe_pkg.sv
sv/qpe_queue.sv
sv/qpe_front.sv
sv/qpe_back.sv
sv/quoted_printable_encoder.sv
sv/qpe_checker.sv
bench/tb.sv
